// ----- rtl/slawc_pkg.sv -----
// Package of the set-associative write-back cache tag store.
// Holds operation codes, controller states and fixed field widths; no dependencies.
package slawc_pkg;

    localparam int STAMP_W      = 63;
    localparam int IN_TDATA_W   = 112;
    localparam int OUT_TDATA_W  = 112;
    localparam int REQ_ADDR_W   = 32;
    localparam int CLEAN_SET_W  = 6;
    localparam int CLEAN_WAY_W  = 3;

    typedef enum logic [1:0] {
        MODE_ACCESS = 2'd0,
        MODE_FILL   = 2'd1,
        MODE_INVAL  = 2'd2,
        MODE_CLEAN  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage

// ----- rtl/slawc_victim.sv -----
// Victim way selection for a fill: lowest invalid way, else oldest stamp.
// Depends on slawc_pkg for the stamp width.
module slawc_victim #(
    parameter int WAYS  = 8,
    parameter int WAY_W = 3
) (
    input  logic [WAYS-1:0]                    i_valid,
    input  logic [WAYS*slawc_pkg::STAMP_W-1:0] i_stamps,
    output logic [WAY_W-1:0]                   o_way
);
    import slawc_pkg::*;

    logic [WAYS-1:0] w_oldest;

    // Each way is compared with every other way in parallel; ties favor the lower way.
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            w_oldest[w] = 1'b1;
            for (int j = 0; j < WAYS; j++) begin
                if (j < w) begin
                    if (!(i_stamps[w*STAMP_W +: STAMP_W] < i_stamps[j*STAMP_W +: STAMP_W])) begin
                        w_oldest[w] = 1'b0;
                    end
                end else if (j > w) begin
                    if (i_stamps[w*STAMP_W +: STAMP_W] > i_stamps[j*STAMP_W +: STAMP_W]) begin
                        w_oldest[w] = 1'b0;
                    end
                end
            end
        end
    end

    always_comb begin
        o_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (w_oldest[w]) begin
                o_way = WAY_W'(w);
            end
        end
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (!i_valid[w]) begin
                o_way = WAY_W'(w);
            end
        end
    end

endmodule

// ----- rtl/set_assoc_lru_writeback_cache.sv -----
// Top level of the set-associative write-back cache tag store with stamp LRU.
// Depends on slawc_pkg and slawc_victim.
//
// Usage: requests arrive as items on the s_axis channel (mode in tuser, the
// other request fields in tdata) and exactly one result item leaves on the
// m_axis channel for each request. All tag, address, dirty, valid and stamp
// state of one set lives in one row of a synchronous memory, so a request is
// a read-modify-write of one row.
// Order: the accepted request's row is read into r_rd_row, then modified and
// written back in ST_EXEC, and the result item is registered for m_axis.
// One request at a time: a new request is taken only once the last one is done.
// Reset: i_rst_n is synchronous and active low. After reset the block walks
// every row once to clear valid and dirty bits, during which s_axis_tready
// stays low.
// Stall: the result is held in an output register until m_axis_tready; a new
// request is taken in the same cycle the waiting result leaves, but not while
// it still waits.
// SETS is expected to be a power of two; the set is the low address bits
// above the line offset.
module set_assoc_lru_writeback_cache #(
    parameter int SETS        = 64,
    parameter int WAYS        = 8,
    parameter int OFFSET_BITS = 6,
    parameter int ADDR_BITS   = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: is_write[0], addr[32:1], time_stamp[95:33], clean_set[101:96],
    // clean_way[104:102], zero fill above
    input  logic [slawc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // tuser: mode[1:0]
    input  logic [1:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: hit[0], writeback_valid[1], writeback_addr[33:2],
    // invalidated_found[34], invalidated_addr[66:35], dirty_total[98:67],
    // last_dirty_set_out[104:99], last_dirty_way_out[107:105], zero fill above
    output logic [slawc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import slawc_pkg::*;

    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ENT_W = 2 + ADDR_BITS + STAMP_W;
    localparam int ROW_W = WAYS * ENT_W;
    localparam int Q_W   = ADDR_BITS - OFFSET_BITS;

    // One memory row per set; each way's entry is {stamp, addr, dirty, valid}.
    logic [ROW_W-1:0] r_mem [SETS];
    logic [ROW_W-1:0] r_rd_row;

    t_state r_state, n_state;

    logic [SET_W-1:0]     r_idx, n_idx;
    logic                 r_clean_ok;
    t_mode                r_mode;
    logic                 r_wr;
    logic [ADDR_BITS-1:0] r_addr;
    logic [STAMP_W-1:0]   r_stamp;
    logic [CLEAN_WAY_W-1:0] r_cway;

    logic [31:0]            r_dirty_cnt, n_dirty_cnt;
    logic [CLEAN_SET_W-1:0] r_last_set, n_last_set;
    logic [CLEAN_WAY_W-1:0] r_last_way, n_last_way;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    logic             w_accept;
    logic             w_mem_we;
    logic [ROW_W-1:0] w_wr_row;
    logic [SET_W-1:0] w_req_set;

    logic [WAYS-1:0]            w_valid;
    logic [WAYS-1:0]            w_match;
    logic [WAYS*STAMP_W-1:0]    w_stamps;
    logic [WAY_W-1:0]           w_hit_way;
    logic                       w_hit;
    logic [WAY_W-1:0]           w_victim;
    logic [ENT_W-1:0]           w_ent;
    logic [Q_W-1:0]             w_q;

    logic        w_hit_o, w_wbv_o, w_invf_o;
    logic [31:0] w_wba_o, w_inva_o;

    assign w_accept  = s_axis_tvalid && s_axis_tready;
    assign w_req_set = s_axis_tdata[1+OFFSET_BITS +: SET_W];

    // Per-way decode of the row that was read.
    always_comb begin
        w_q = r_addr[ADDR_BITS-1:OFFSET_BITS];
        for (int w = 0; w < WAYS; w++) begin
            w_valid[w] = r_rd_row[w*ENT_W];
            w_stamps[w*STAMP_W +: STAMP_W] = r_rd_row[w*ENT_W+2+ADDR_BITS +: STAMP_W];
            w_match[w] = w_valid[w] &&
                         (r_rd_row[w*ENT_W+2+OFFSET_BITS +: Q_W] == w_q);
        end
        w_hit     = |w_match;
        w_hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (w_match[w]) begin
                w_hit_way = WAY_W'(w);
            end
        end
    end

    slawc_victim #(
        .WAYS  (WAYS),
        .WAY_W (WAY_W)
    ) u_victim (
        .i_valid  (w_valid),
        .i_stamps (w_stamps),
        .o_way    (w_victim)
    );

    // Modify the row and work out the result.
    always_comb begin
        w_wr_row    = r_rd_row;
        w_mem_we    = 1'b0;
        w_ent       = '0;
        n_dirty_cnt = r_dirty_cnt;
        n_last_set  = r_last_set;
        n_last_way  = r_last_way;
        w_hit_o     = 1'b0;
        w_wbv_o     = 1'b0;
        w_wba_o     = '0;
        w_invf_o    = 1'b0;
        w_inva_o    = '0;
        case (r_mode)
            MODE_ACCESS: begin
                if (w_hit) begin
                    w_hit_o  = 1'b1;
                    w_mem_we = 1'b1;
                    w_ent    = r_rd_row[w_hit_way*ENT_W +: ENT_W];
                    w_ent[2+ADDR_BITS +: STAMP_W] = r_stamp;
                    if (r_wr) begin
                        w_ent[1]    = 1'b1;
                        n_dirty_cnt = r_dirty_cnt + 32'd1;
                        n_last_set  = CLEAN_SET_W'(r_idx);
                        n_last_way  = CLEAN_WAY_W'(w_hit_way);
                    end
                    w_wr_row[w_hit_way*ENT_W +: ENT_W] = w_ent;
                end
            end
            MODE_FILL: begin
                w_ent = r_rd_row[w_victim*ENT_W +: ENT_W];
                if (w_ent[0] && w_ent[1]) begin
                    w_wbv_o = 1'b1;
                    w_wba_o = 32'(w_ent[2 +: ADDR_BITS]);
                end
                w_mem_we = 1'b1;
                w_ent    = {r_stamp, r_addr, r_wr, 1'b1};
                if (r_wr) begin
                    n_dirty_cnt = r_dirty_cnt + 32'd1;
                    n_last_set  = CLEAN_SET_W'(r_idx);
                    n_last_way  = CLEAN_WAY_W'(w_victim);
                end
                w_wr_row[w_victim*ENT_W +: ENT_W] = w_ent;
            end
            MODE_INVAL: begin
                if (w_hit) begin
                    w_ent    = r_rd_row[w_hit_way*ENT_W +: ENT_W];
                    w_invf_o = 1'b1;
                    w_inva_o = 32'(w_ent[2 +: ADDR_BITS]);
                    w_mem_we = 1'b1;
                    w_ent[1:0]  = 2'b00;
                    n_dirty_cnt = r_dirty_cnt - 32'd1;
                    w_wr_row[w_hit_way*ENT_W +: ENT_W] = w_ent;
                end
            end
            MODE_CLEAN: begin
                w_mem_we = r_clean_ok;
                for (int w = 0; w < WAYS; w++) begin
                    if (32'(r_cway) == w) begin
                        w_wr_row[w*ENT_W+1] = 1'b0;
                    end
                end
            end
            default: begin
                w_mem_we = 1'b0;
            end
        endcase
        n_out_data = '0;
        n_out_data[0]      = w_hit_o;
        n_out_data[1]      = w_wbv_o;
        n_out_data[33:2]   = w_wba_o;
        n_out_data[34]     = w_invf_o;
        n_out_data[66:35]  = w_inva_o;
        n_out_data[98:67]  = n_dirty_cnt;
        n_out_data[104:99] = n_last_set;
        n_out_data[107:105] = n_last_way;
    end

    // Controller: clearing sweep, then one request at a time.
    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        s_axis_tready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                n_idx = r_idx + SET_W'(1);
                if (32'(r_idx) == SETS - 1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_axis_tready = !r_out_valid || m_axis_tready;
                if (w_accept) begin
                    n_state = ST_EXEC;
                    if (t_mode'(s_axis_tuser) == MODE_CLEAN) begin
                        n_idx = SET_W'(s_axis_tdata[101:96]);
                    end else begin
                        n_idx = w_req_set;
                    end
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_dirty_cnt <= '0;
            r_last_set  <= '0;
            r_last_way  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (r_state == ST_EXEC) begin
                r_out_valid <= 1'b1;
                r_dirty_cnt <= n_dirty_cnt;
                r_last_set  <= n_last_set;
                r_last_way  <= n_last_way;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request payload and result payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode     <= t_mode'(s_axis_tuser);
            r_wr       <= s_axis_tdata[0];
            r_addr     <= s_axis_tdata[1 +: ADDR_BITS];
            r_stamp    <= s_axis_tdata[95:33];
            r_cway     <= s_axis_tdata[104:102];
            r_clean_ok <= 32'(s_axis_tdata[101:96]) < SETS;
        end
        if (r_state == ST_EXEC) begin
            r_out_data <= n_out_data;
        end
    end

    // Row memory: one read port, one write port.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) begin
            r_mem[r_idx] <= '0;
        end else if (r_state == ST_EXEC && w_mem_we) begin
            r_mem[r_idx] <= w_wr_row;
        end
        r_rd_row <= r_mem[n_idx];
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- rtl/slawc_checker.sv -----
// Port-level checker for the cache tag store, bound to the top level.
// Depends on slawc_pkg for the channel widths.
module slawc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [slawc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import slawc_pkg::*;

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // An accepted request is followed by a valid result.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)
        else $error("result missing two cycles after request");

    // One request at a time: no accept in the cycle after an accept.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while another is in flight");

    // The dirty counter moves by at most one between consecutive results.
    a_dirty_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) && $past(m_axis_tvalid, 3) |->
        (m_axis_tdata[98:67] == $past(m_axis_tdata[98:67], 3)) ||
        (m_axis_tdata[98:67] == $past(m_axis_tdata[98:67], 3) + 32'd1) ||
        (m_axis_tdata[98:67] == $past(m_axis_tdata[98:67], 3) - 32'd1))
        else $error("dirty counter jumped");

endmodule

bind set_assoc_lru_writeback_cache slawc_checker u_slawc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/sv/tb_slawc_checker.sv -----
// Checker for the set-associative write-back cache tag store.
// Watches both stream channels, predicts each result and compares it; depends on slawc_pkg.
module tb_slawc_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic [slawc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [1:0]                        s_axis_tuser,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [slawc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output int                                o_fail_count,
    output int                                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import slawc_pkg::*;

    localparam int NSETS = 64;
    localparam int NWAYS = 8;
    localparam int OFS   = 6;

    typedef struct packed {
        logic [2:0]  last_way;
        logic [5:0]  last_set;
        logic [31:0] dirty_total;
        logic [31:0] inv_addr;
        logic        inv_found;
        logic [31:0] wb_addr;
        logic        wb_valid;
        logic        hit;
    } t_result;

    logic        tag_valid [NSETS][NWAYS];
    logic        tag_dirty [NSETS][NWAYS];
    logic [19:0] tag_bits  [NSETS][NWAYS];
    logic [31:0] line_addr [NSETS][NWAYS];
    logic [62:0] stamp     [NSETS][NWAYS];
    logic [31:0] dirty_cnt;
    logic [5:0]  last_set;
    logic [2:0]  last_way;
    t_result     expected_results [$];

    function automatic void note_dirty(int s, int w);
        tag_dirty[s][w] = 1'b1;
        dirty_cnt       = dirty_cnt + 1;
        last_set        = s[5:0];
        last_way        = w[2:0];
    endfunction

    function automatic int find_way(int s, logic [19:0] tg);
        for (int w = 0; w < NWAYS; w++)
            if (tag_valid[s][w] && tag_bits[s][w] == tg) return w;
        return -1;
    endfunction

    function automatic t_result predict_cache(t_mode md, logic [IN_TDATA_W-1:0] d);
        logic        wr;
        logic [31:0] a;
        logic [62:0] now;
        int          s, w, v;
        logic [19:0] tg;
        t_result     r;
        wr  = d[0];
        a   = d[32:1];
        now = d[95:33];
        s   = a[OFS+5:OFS];
        tg  = a[31:OFS+6];
        r   = '0;
        case (md)
            MODE_ACCESS: begin
                w = find_way(s, tg);
                if (w >= 0) begin
                    r.hit = 1'b1;
                    if (wr) note_dirty(s, w);
                    stamp[s][w] = now;
                end
            end
            MODE_FILL: begin
                v = -1;
                for (int k = 0; k < NWAYS; k++)
                    if (v < 0 && !tag_valid[s][k]) v = k;
                if (v < 0) begin
                    v = 0;
                    for (int k = 1; k < NWAYS; k++)
                        if (stamp[s][k] < stamp[s][v]) v = k;
                end
                if (tag_valid[s][v] && tag_dirty[s][v]) begin
                    r.wb_valid = 1'b1;
                    r.wb_addr  = line_addr[s][v];
                end
                tag_valid[s][v] = 1'b1;
                tag_bits[s][v]  = tg;
                line_addr[s][v] = a;
                tag_dirty[s][v] = 1'b0;
                if (wr) note_dirty(s, v);
                stamp[s][v] = now;
            end
            MODE_INVAL: begin
                w = find_way(s, tg);
                if (w >= 0) begin
                    tag_valid[s][w] = 1'b0;
                    tag_dirty[s][w] = 1'b0;
                    dirty_cnt       = dirty_cnt - 1;
                    r.inv_found     = 1'b1;
                    r.inv_addr      = line_addr[s][w];
                end
            end
            default: begin
                // Clean set and way fields cover exactly the array, so never out of range.
                tag_dirty[d[101:96]][d[104:102]] = 1'b0;
            end
        endcase
        r.dirty_total = dirty_cnt;
        r.last_set    = last_set;
        r.last_way    = last_way;
        return r;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_result got, exp_r;
        if (!i_rst_n) begin
            for (int s = 0; s < NSETS; s++)
                for (int w = 0; w < NWAYS; w++) begin
                    tag_valid[s][w] = 1'b0;
                    tag_dirty[s][w] = 1'b0;
                    tag_bits[s][w]  = '1;
                    line_addr[s][w] = '0;
                    stamp[s][w]     = '0;
                end
            dirty_cnt = '0;
            last_set  = '0;
            last_way  = '0;
            o_fail_count = 0;
            expected_results.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata[107:0]);
                if (expected_results.size() == 0) begin
                    $error("unexpected result item %h", m_axis_tdata);
                    o_fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got.hit !== exp_r.hit) begin
                        $error("hit exp %0d got %0d", exp_r.hit, got.hit); o_fail_count++;
                    end
                    if (got.wb_valid !== exp_r.wb_valid) begin
                        $error("writeback_valid exp %0d got %0d", exp_r.wb_valid, got.wb_valid);
                        o_fail_count++;
                    end
                    if (got.wb_addr !== exp_r.wb_addr) begin
                        $error("writeback_addr exp %h got %h", exp_r.wb_addr, got.wb_addr);
                        o_fail_count++;
                    end
                    if (got.inv_found !== exp_r.inv_found) begin
                        $error("invalidated_found exp %0d got %0d", exp_r.inv_found,
                               got.inv_found);
                        o_fail_count++;
                    end
                    if (got.inv_addr !== exp_r.inv_addr) begin
                        $error("invalidated_addr exp %h got %h", exp_r.inv_addr, got.inv_addr);
                        o_fail_count++;
                    end
                    if (got.dirty_total !== exp_r.dirty_total) begin
                        $error("dirty_total exp %0d got %0d", $signed(exp_r.dirty_total),
                               $signed(got.dirty_total));
                        o_fail_count++;
                    end
                    if (got.last_set !== exp_r.last_set) begin
                        $error("last_dirty_set_out exp %0d got %0d", exp_r.last_set,
                               got.last_set);
                        o_fail_count++;
                    end
                    if (got.last_way !== exp_r.last_way) begin
                        $error("last_dirty_way_out exp %0d got %0d", exp_r.last_way,
                               got.last_way);
                        o_fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(predict_cache(t_mode'(s_axis_tuser), s_axis_tdata));
        end
    end
endmodule

// ----- tb/sv/tb_set_assoc_lru_writeback_cache.sv -----
// Testbench top of the set-associative write-back cache tag store.
// Drives request items and the result-side ready; depends on slawc_pkg and tb_slawc_checker.
module tb_set_assoc_lru_writeback_cache;
    timeunit 1ns;
    timeprecision 1ps;
    import slawc_pkg::*;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]             s_axis_tuser = MODE_ACCESS;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    int                     fail_count;
    int                     pending;
    int                     src_idle_pct = 0;
    int                     dst_stall_pct = 0;
    int                     hold_cycles = 0;
    logic                   hold_go = 1'b0;
    int                     cycle_count = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    set_assoc_lru_writeback_cache i_dut (.*);

    tb_slawc_checker i_checker (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Result-side ready: random stalls at the phase rate, or a solid hold-off
    // while hold_cycles counts down after a hold_go pulse.
    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_cycles   <= 300;
            m_axis_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= dst_stall_pct);
        end
    end

    // Hard run limit; the run is stopped with an error once it is reached.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 200000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offers one item, with random idle cycles before it, and returns once it is taken.
    task automatic send_req(t_mode md, logic wr, logic [31:0] a, logic [62:0] ts,
                            logic [5:0] cs, logic [2:0] cw);
        if ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= md;
        s_axis_tdata  <= {7'd0, cw, cs, ts, a, wr};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Addresses in a few sets and a few tags per set, so lines collide and get evicted.
    function automatic logic [31:0] pick_addr();
        logic [31:0] a;
        a = $urandom;
        a[11:6] = 6'($urandom_range(3));
        a[31:12] = 20'($urandom_range(11));
        if ($urandom_range(9) == 0) a = $urandom;
        return a;
    endfunction

    task automatic random_phase(int n, int idle, int stall);
        int r;
        src_idle_pct  = idle;
        dst_stall_pct = stall;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(9);
            send_req(r < 4 ? MODE_ACCESS : r < 7 ? MODE_FILL : r < 9 ? MODE_INVAL : MODE_CLEAN,
                     1'($urandom_range(1)), pick_addr(),
                     63'({$urandom, $urandom}),
                     6'($urandom_range(63)), 3'($urandom_range(7)));
        end
    endtask

    initial begin
        logic [31:0] base;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: fill all eight ways of set 5 dirty, hit, then force an LRU eviction
        // with equal stamps (tie goes to the lowest way) and extremes of every field.
        base = 32'h0000_0140;
        for (int w = 0; w < 8; w++)
            send_req(MODE_FILL, 1'b1, base + (w << 12), 63'd7, 6'd0, 3'd0);
        send_req(MODE_ACCESS, 1'b1, base + (3 << 12), '1, 6'd0, 3'd0);
        send_req(MODE_ACCESS, 1'b0, base + (9 << 12), '0, 6'd0, 3'd0);
        send_req(MODE_FILL, 1'b0, base + (20 << 12), 63'd1, 6'd0, 3'd0);
        send_req(MODE_FILL, 1'b0, base + (21 << 12), 63'd1, 6'd0, 3'd0);
        send_req(MODE_CLEAN, 1'b0, '0, '0, 6'd5, 3'd2);
        send_req(MODE_CLEAN, 1'b1, '1, '1, 6'd63, 3'd7);
        send_req(MODE_FILL, 1'b1, base + (20 << 12), 63'd2, 6'd0, 3'd0);
        send_req(MODE_INVAL, 1'b0, base + (20 << 12), '0, 6'd0, 3'd0);
        send_req(MODE_INVAL, 1'b0, base + (20 << 12), '0, 6'd0, 3'd0);
        send_req(MODE_INVAL, 1'b1, 32'hdead_beef, '0, 6'd0, 3'd0);
        send_req(MODE_FILL, 1'b1, 32'hffff_ffff, '1, '1, '1);
        send_req(MODE_ACCESS, 1'b1, 32'hffff_ffc0, 63'd3, '1, '1);
        send_req(MODE_FILL, 1'b0, 32'h0000_0000, '0, '0, '0);
        send_req(MODE_INVAL, 1'b0, 32'hffff_ffff, '0, '0, '0);
        // Invalidates of the lines filled first in set 5, clean and dirty alike, each lower the counter when they hit.
        for (int w = 0; w < 4; w++)
            send_req(MODE_INVAL, 1'b0, base + (w << 12), '0, 6'd0, 3'd0);

        random_phase(200, 0, 0);
        random_phase(200, 74, 0);
        random_phase(200, 0, 74);
        random_phase(170, 17, 17);

        // Long hold-off while the sender keeps offering items, so the block backs up.
        src_idle_pct = 0;
        dst_stall_pct = 0;
        hold_go <= 1'b1;
        @(posedge i_clk);
        hold_go <= 1'b0;
        random_phase(60, 0, 0);
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/slawc_pkg.sv
rtl/slawc_victim.sv
rtl/set_assoc_lru_writeback_cache.sv
rtl/slawc_checker.sv
tb/sv/tb_slawc_checker.sv
tb/sv/tb_set_assoc_lru_writeback_cache.sv
